/* sv/gha_pkg.sv */
// Shared types and constants of the generational handle allocator.
`default_nettype none
package gha_pkg;

    localparam int IDX_W     = 10;
    localparam int GEN_W     = 24;
    localparam int MAXBLK_W  = 5;
    localparam int DATA_W    = 40;
    localparam int CFG_IDX_W = 1;

    typedef enum logic {
        REQ_ALLOC   = 1'b0,
        REQ_RELEASE = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMEM   = 2'd1,
        ST_RETIRED = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_BLOCKS    = 1'd0,
        CFG_NEVER_REISSUE = 1'd1
    } cfg_reg_t;

endpackage
`default_nettype wire

/* sv/generational_handle_allocator_core.sv */
// Top level of the generational handle allocator: sequencer, list heads and stores.
//
//  channel  dir  handshake                fields
//  s_axis   in   s_axis_tvalid/tready     tuser: req_type; tdata: in_index, in_generation
//  m_axis   out  m_axis_tvalid/tready     tuser: status; tdata: out_index, out_generation
//  cfg      in   cfg_valid/cfg_ready      cfg_index, cfg_data
//
// Allocate from a list: S_ALLOC, S_A_RD, S_A_WB, S_OUT, set by the registered memory read
// and the read-modify-write of the link store. Release: S_R_RD, S_R_WB, S_OUT, or S_OUT
// alone for an index not yet in use. A deferred list swap adds an S_ALLOC pass; a failed
// allocation: S_ALLOC, S_OUT. Block growth adds S_GROW, one store entry per cycle through
// the incrementer. After reset, block zero is filled while s_axis_tready is low.
// A stalled result holds the sequencer in its last state; cfg is always ready.
`default_nettype none
module generational_handle_allocator_core #(
    parameter int PER_BLOCK = 64,
    parameter int BLOCKS    = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [gha_pkg::DATA_W-1:0]      s_axis_tdata,  // in_index, in_generation
    input  wire logic                            s_axis_tuser,  // req_type
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [gha_pkg::DATA_W-1:0]      m_axis_tdata,  // out_index, out_generation
    output logic      [1:0]                      m_axis_tuser,  // status
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [gha_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gha_pkg::MAXBLK_W-1:0]    cfg_data
);

    localparam int TOTAL = PER_BLOCK * BLOCKS;
    localparam int AW    = $clog2(TOTAL);
    localparam int CW    = $clog2(TOTAL + 1);
    localparam int NW    = $clog2(BLOCKS + 1);
    localparam int LW    = AW + 1;
    localparam int IW    = gha_pkg::IDX_W;
    localparam int GW    = gha_pkg::GEN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_GROW,
        S_A_RD,
        S_A_WB,
        S_R_RD,
        S_R_WB,
        S_OUT
    } state_t;

    state_t                   state_reg, state_next;
    logic [AW-1:0]            slot_reg, slot_next;
    logic                     free_v_reg, free_v_next;
    logic [AW-1:0]            free_i_reg, free_i_next;
    logic                     def_v_reg, def_v_next;
    logic [AW-1:0]            def_i_reg, def_i_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [NW-1:0]            nblk_reg, nblk_next;
    logic [CW-1:0]            p_reg, p_next;
    logic [CW-1:0]            end_reg, end_next;
    logic                     init_reg, init_next;
    logic [IW-1:0]            res_idx_reg, res_idx_next;
    logic [GW-1:0]            res_gen_reg, res_gen_next;
    gha_pkg::status_t         res_st_reg, res_st_next;
    logic                     out_v_reg, out_v_next;
    logic [IW-1:0]            out_idx_reg, out_idx_next;
    logic [GW-1:0]            out_gen_reg, out_gen_next;
    gha_pkg::status_t         out_st_reg, out_st_next;
    logic [gha_pkg::MAXBLK_W-1:0] max_blocks_reg, max_blocks_next;
    logic                     never_reissue_reg, never_reissue_next;

    logic                     link_we, gen_we;
    logic [AW-1:0]            waddr;
    logic [LW-1:0]            link_wdata, link_rdata;
    logic [GW-1:0]            gen_wdata, gen_rdata;
    logic [GW-1:0]            inc_a, inc_sum;
    logic                     inc_wrap;
    logic                     grow_last;
    logic                     grow_ok;
    logic                     in_acc;

    gha_ram #(.WIDTH(LW), .DEPTH(TOTAL)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (waddr),
        .wdata (link_wdata),
        .raddr (slot_reg),
        .rdata (link_rdata)
    );

    gha_ram #(.WIDTH(GW), .DEPTH(TOTAL)) u_gen_ram (
        .clk   (clk),
        .we    (gen_we),
        .waddr (waddr),
        .wdata (gen_wdata),
        .raddr (slot_reg),
        .rdata (gen_rdata)
    );

    gha_inc u_inc (
        .a    (inc_a),
        .sum  (inc_sum),
        .wrap (inc_wrap)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {{(gha_pkg::DATA_W - IW - GW){1'b0}}, out_gen_reg, out_idx_reg};
    assign m_axis_tuser  = out_st_reg;

    assign inc_a     = (state_reg == S_GROW) ? GW'(p_reg) : gen_rdata;
    assign grow_last = (CW'(inc_sum) == end_reg);
    assign grow_ok   = (32'(nblk_reg) < 32'(max_blocks_reg)) && (32'(nblk_reg) < BLOCKS);

    always_comb
    begin
        link_we    = 1'b0;
        gen_we     = 1'b0;
        waddr      = slot_reg;
        link_wdata = '0;
        gen_wdata  = inc_sum;
        case (state_reg)
            S_GROW:
            begin
                link_we    = 1'b1;
                gen_we     = 1'b1;
                waddr      = p_reg[AW-1:0];
                link_wdata = grow_last ? {free_v_reg, free_i_reg} : {1'b1, AW'(inc_sum)};
                gen_wdata  = (init_reg && p_reg == '0) ? GW'(1) : '0;
            end
            S_A_WB:
            begin
                link_we    = 1'b1;
                link_wdata = '0;
            end
            S_R_WB:
            begin
                gen_we     = 1'b1;
                gen_wdata  = (inc_wrap && slot_reg == '0 && !never_reissue_reg) ?
                             GW'(1) : inc_sum;
                link_we    = !(inc_wrap && never_reissue_reg);
                link_wdata = {def_v_reg, def_i_reg};
            end
            default:
            begin
                link_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next         = state_reg;
        slot_next          = slot_reg;
        free_v_next        = free_v_reg;
        free_i_next        = free_i_reg;
        def_v_next         = def_v_reg;
        def_i_next         = def_i_reg;
        count_next         = count_reg;
        nblk_next          = nblk_reg;
        p_next             = p_reg;
        end_next           = end_reg;
        init_next          = init_reg;
        res_idx_next       = res_idx_reg;
        res_gen_next       = res_gen_reg;
        res_st_next        = res_st_reg;
        out_v_next         = out_v_reg && !m_axis_tready;
        out_idx_next       = out_idx_reg;
        out_gen_next       = out_gen_reg;
        out_st_next        = out_st_reg;
        max_blocks_next    = max_blocks_reg;
        never_reissue_next = never_reissue_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                gha_pkg::CFG_MAX_BLOCKS:    max_blocks_next    = cfg_data;
                gha_pkg::CFG_NEVER_REISSUE: never_reissue_next = cfg_data[0];
                default:                    max_blocks_next    = max_blocks_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    res_idx_next = '0;
                    res_gen_next = '0;
                    res_st_next  = gha_pkg::ST_OK;
                    slot_next    = AW'(s_axis_tdata[IW-1:0]);
                    if (s_axis_tuser == gha_pkg::REQ_ALLOC)
                    begin
                        state_next = S_ALLOC;
                    end
                    else if (32'(s_axis_tdata[IW-1:0]) >= 32'(count_reg))
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_R_RD;
                    end
                end
            end
            S_ALLOC:
            begin
                if (free_v_reg)
                begin
                    slot_next  = free_i_reg;
                    state_next = S_A_RD;
                end
                else if (def_v_reg)
                begin
                    free_v_next = 1'b1;
                    free_i_next = def_i_reg;
                    def_v_next  = 1'b0;
                    def_i_next  = '0;
                end
                else if (grow_ok)
                begin
                    p_next     = count_reg;
                    end_next   = CW'(32'(count_reg) + PER_BLOCK);
                    state_next = S_GROW;
                end
                else
                begin
                    res_st_next = gha_pkg::ST_NOMEM;
                    state_next  = S_OUT;
                end
            end
            S_GROW:
            begin
                p_next = CW'(inc_sum);
                if (grow_last)
                begin
                    free_v_next = 1'b1;
                    free_i_next = count_reg[AW-1:0];
                    count_next  = end_reg;
                    nblk_next   = nblk_reg + NW'(1);
                    init_next   = 1'b0;
                    state_next  = init_reg ? S_IDLE : S_ALLOC;
                end
            end
            S_A_RD:
            begin
                state_next = S_A_WB;
            end
            S_A_WB:
            begin
                free_v_next  = link_rdata[LW-1];
                free_i_next  = link_rdata[AW-1:0];
                res_idx_next = IW'(slot_reg);
                res_gen_next = gen_rdata;
                state_next   = S_OUT;
            end
            S_R_RD:
            begin
                state_next = S_R_WB;
            end
            S_R_WB:
            begin
                if (inc_wrap && never_reissue_reg)
                begin
                    res_st_next = gha_pkg::ST_RETIRED;
                end
                else
                begin
                    def_v_next = 1'b1;
                    def_i_next = slot_reg;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_v_reg || m_axis_tready)
                begin
                    out_v_next   = 1'b1;
                    out_idx_next = res_idx_reg;
                    out_gen_next = res_gen_reg;
                    out_st_next  = res_st_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_GROW;
            free_v_reg        <= 1'b0;
            free_i_reg        <= '0;
            def_v_reg         <= 1'b0;
            def_i_reg         <= '0;
            count_reg         <= '0;
            nblk_reg          <= '0;
            p_reg             <= '0;
            end_reg           <= CW'(PER_BLOCK);
            init_reg          <= 1'b1;
            out_v_reg         <= 1'b0;
            max_blocks_reg    <= gha_pkg::MAXBLK_W'(16);
            never_reissue_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            free_v_reg        <= free_v_next;
            free_i_reg        <= free_i_next;
            def_v_reg         <= def_v_next;
            def_i_reg         <= def_i_next;
            count_reg         <= count_next;
            nblk_reg          <= nblk_next;
            p_reg             <= p_next;
            end_reg           <= end_next;
            init_reg          <= init_next;
            out_v_reg         <= out_v_next;
            max_blocks_reg    <= max_blocks_next;
            never_reissue_reg <= never_reissue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        res_idx_reg <= res_idx_next;
        res_gen_reg <= res_gen_next;
        res_st_reg  <= res_st_next;
        out_idx_reg <= out_idx_next;
        out_gen_reg <= out_gen_next;
        out_st_reg  <= out_st_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= TOTAL)
        else $error("slot count beyond store depth");

    a_count_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == 32'(nblk_reg) * PER_BLOCK)
        else $error("slot count out of step with block count");

    a_nomem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_st_reg == gha_pkg::ST_NOMEM) |->
        (out_idx_reg == '0 && out_gen_reg == '0))
        else $error("failed allocation carries a handle");

    a_grow_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GROW && grow_last) |=> free_v_reg)
        else $error("free head not valid after block fill");

endmodule
`default_nettype wire

/* sv/gha_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* sv/gha_inc.sv */
// Shared incrementer: slot pointer during block fill, generation bump on release.
`default_nettype none
module gha_inc (
    input  wire logic [gha_pkg::GEN_W-1:0] a,
    output logic      [gha_pkg::GEN_W-1:0] sum,
    output logic                           wrap
);

    always_comb
    begin
        sum  = a + gha_pkg::GEN_W'(1);
        wrap = (sum == '0);
    end

endmodule
`default_nettype wire
